@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the transcoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define U2U_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/u2u_pkg.sv @@
// ---------------------------------------------------------------------------
// u2u_pkg
// Types, constants and the byte classifier shared by the transcoder modules.
// ---------------------------------------------------------------------------
package u2u_pkg;

  // Input beat: one UTF-8 byte and the end-of-string flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } u2u_in_t;

  // Output beat: one UTF-16 code unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } u2u_out_t;

  // Byte class; lead codes equal the sequence length
  typedef enum logic [2:0] {
    CLS_CONT    = 3'd0,
    CLS_ASCII   = 3'd1,
    CLS_LEAD2   = 3'd2,
    CLS_LEAD3   = 3'd3,
    CLS_LEAD4   = 3'd4,
    CLS_INVALID = 3'd5
  } u2u_class_t;

  // Work for the back end: leading '?' units, up to two decoded units,
  // trailing '?' units, and the total count
  typedef struct packed {
    logic [1:0]  q_pre;
    logic [1:0]  main_cnt;
    logic [15:0] main0;
    logic [15:0] main1;
    logic [1:0]  q_post;
    logic [2:0]  total;
    logic        eos;
  } u2u_desc_t;

  localparam logic [15:0] UNIT_QMARK     = 16'h003F;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE      = 21'h10000;

  // Class from the top five bits of a byte
  function automatic u2u_class_t u2u_classify(input logic [7:0] b);
    u2u_class_t c;
    case (b[7:3]) inside
      [5'd0:5'd15]:  c = CLS_ASCII;
      [5'd16:5'd23]: c = CLS_CONT;
      [5'd24:5'd27]: c = CLS_LEAD2;
      [5'd28:5'd29]: c = CLS_LEAD3;
      5'd30:         c = CLS_LEAD4;
      default:       c = CLS_INVALID;
    endcase
    return c;
  endfunction

endpackage

@@ design/u2u_front.sv @@
// ---------------------------------------------------------------------------
// u2u_front
// Accepts bytes, tracks the pending sequence and issues one work
// descriptor per byte that yields any code units.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u2u_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  u2u_pkg::u2u_in_t   in_data,
  output logic               push,
  output u2u_pkg::u2u_desc_t push_data,
  input  logic               q_ready
);
  import u2u_pkg::*;

  logic [2:0]  seq_len_r, seq_len_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [20:0] point_r, point_nxt;

  u2u_class_t  cls;
  logic [7:0]  b;
  logic        fresh;
  logic        accept;
  logic [20:0] acc_point;
  logic [20:0] supp_off;
  u2u_desc_t   desc;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Classify the byte and work out its units and the next state
  always_comb begin
    b         = in_data.in_byte;
    cls       = u2u_classify(b);
    acc_point = {point_r[14:0], b[5:0]};
    supp_off  = acc_point - SUPP_BASE;

    seq_len_nxt = seq_len_r;
    held_nxt    = held_r;
    point_nxt   = point_r;
    desc        = '0;
    desc.eos    = in_data.end_of_string;
    fresh       = 1'b1;

    if (seq_len_r != 3'd0) begin
      if (cls == CLS_CONT) begin
        fresh = 1'b0;
        if (({1'b0, held_r} + 3'd1) >= seq_len_r) begin
          // sequence complete: one unit or a surrogate pair
          if (acc_point[20:16] != 5'd0) begin
            desc.main_cnt = 2'd2;
            desc.main0    = HIGH_SURR_BASE + {5'b0, supp_off[20:10]};
            desc.main1    = LOW_SURR_BASE + {6'b0, supp_off[9:0]};
          end else begin
            desc.main_cnt = 2'd1;
            desc.main0    = acc_point[15:0];
          end
          seq_len_nxt = 3'd0;
          held_nxt    = 2'd0;
          point_nxt   = '0;
        end else begin
          held_nxt  = held_r + 2'd1;
          point_nxt = acc_point;
        end
      end else begin
        // broken sequence: one '?' per held byte, then decode anew
        desc.q_pre  = held_r;
        seq_len_nxt = 3'd0;
        held_nxt    = 2'd0;
        point_nxt   = '0;
      end
    end

    if (fresh) begin
      case (cls)
        CLS_ASCII: begin
          desc.main_cnt = 2'd1;
          desc.main0    = {8'h00, b};
        end
        CLS_LEAD2: begin
          seq_len_nxt = cls;
          held_nxt    = 2'd1;
          point_nxt   = {16'b0, b[4:0]};
        end
        CLS_LEAD3: begin
          seq_len_nxt = cls;
          held_nxt    = 2'd1;
          point_nxt   = {17'b0, b[3:0]};
        end
        CLS_LEAD4: begin
          seq_len_nxt = cls;
          held_nxt    = 2'd1;
          point_nxt   = {18'b0, b[2:0]};
        end
        default: begin
          // stray continuation or invalid lead
          desc.main_cnt = 2'd1;
          desc.main0    = UNIT_QMARK;
        end
      endcase
    end

    // end of string: flush a truncated sequence
    if (in_data.end_of_string && (seq_len_nxt != 3'd0)) begin
      desc.q_post = held_nxt;
      seq_len_nxt = 3'd0;
      held_nxt    = 2'd0;
      point_nxt   = '0;
    end

    desc.total = {1'b0, desc.q_pre} + {1'b0, desc.main_cnt} + {1'b0, desc.q_post};
  end

  assign push      = accept && (desc.total != 3'd0);
  assign push_data = desc;

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= 3'd0;
      held_r    <= 2'd0;
      point_r   <= '0;
    end else if (accept) begin
      seq_len_r <= seq_len_nxt;
      held_r    <= held_nxt;
      point_r   <= point_nxt;
    end
  end

  `U2U_ASSERT_NOW(a_held_in_range, seq_len_r != 3'd0,
    (held_r != 2'd0) && ({1'b0, held_r} < seq_len_r), "held count out of range")
  `U2U_ASSERT_NEXT(a_eos_clears, accept && in_data.end_of_string,
    (seq_len_r == 3'd0) && (held_r == 2'd0), "state not cleared after end of string")
  `U2U_ASSERT_NOW(a_eos_yields, accept && in_data.end_of_string,
    push, "end of string gave no unit")

endmodule

@@ design/u2u_queue.sv @@
// ---------------------------------------------------------------------------
// u2u_queue
// Small FIFO of work descriptors between the front and back ends.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u2u_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u2u_pkg::u2u_desc_t push_data,
  output logic               q_ready,
  input  logic               pop,
  output logic               q_valid,
  output u2u_pkg::u2u_desc_t head
);
  import u2u_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u2u_desc_t      mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign q_ready = (count_r != CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `U2U_ASSERT_NOW(a_no_push_full, push, q_ready, "push into full queue")
  `U2U_ASSERT_NOW(a_no_pop_empty, pop, q_valid, "pop from empty queue")

endmodule

@@ design/u2u_back.sv @@
// ---------------------------------------------------------------------------
// u2u_back
// Expands each descriptor into code units and loads them into the output
// register, one per cycle while that register is empty or being taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u2u_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  u2u_pkg::u2u_desc_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u2u_pkg::u2u_out_t  out_data
);
  import u2u_pkg::*;

  logic [1:0]  k_r;
  logic        out_valid_r;
  u2u_out_t    out_data_r;

  logic [2:0]  k_ext;
  logic [2:0]  main_end;
  logic [2:0]  main_idx;
  logic        last_of_desc;
  logic        load;
  logic [15:0] unit;

  assign k_ext        = {1'b0, k_r};
  assign main_end     = {1'b0, head.q_pre} + {1'b0, head.main_cnt};
  assign main_idx     = k_ext - {1'b0, head.q_pre};
  assign last_of_desc = (k_ext == (head.total - 3'd1));
  assign load         = q_valid && (!out_valid_r || out_ready);
  assign pop          = load && last_of_desc;

  // Select the unit at the current position of the descriptor
  always_comb begin
    if (k_ext < {1'b0, head.q_pre}) begin
      unit = UNIT_QMARK;
    end else if (k_ext < main_end) begin
      unit = (main_idx == 3'd0) ? head.main0 : head.main1;
    end else begin
      unit = UNIT_QMARK;
    end
  end

  // Position counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      k_r         <= last_of_desc ? 2'd0 : k_r + 2'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.code_unit <= unit;
      out_data_r.last_unit <= head.eos && last_of_desc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `U2U_ASSERT_NOW(a_pos_in_desc, q_valid, k_ext < head.total, "position beyond descriptor")

endmodule

@@ design/utf8_to_utf16_transcoder.sv @@
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out.
// ---------------------------------------------------------------------------
// Input channel in_*: one UTF-8 byte per beat, with end_of_string on the
// final byte of a string. Output channel out_*: one UTF-16 code unit per
// beat, last_unit set on the final unit of a string. Both are valid/ready.
// Undecodable bytes come out as '?' (0x003F), one per byte.
// Path: a byte completing a unit is written into the descriptor queue when
// it is accepted; the back end then loads that unit into the output register,
// where out_valid rises, once that register is empty or being taken.
// Throughput: one byte per cycle while each byte yields at most one unit;
// the back end emits one unit per cycle while the receiver is ready, so
// a byte yielding several units (up to four) holds it for each in turn. A
// queue of QUEUE_DEPTH descriptors takes up the difference; in_ready drops
// only when it is full. When the receiver stalls, the output register holds
// its beat and the queue keeps filling; bytes that yield nothing are always
// taken while the queue has room. Reset (rst_n low, synchronous) clears any
// pending sequence, empties the queue and drops out_valid.
// ---------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u2u_pkg::u2u_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output u2u_pkg::u2u_out_t out_data
);
  import u2u_pkg::*;

  logic      push, q_ready, q_valid, pop;
  u2u_desc_t push_data, head;

  // Front end: classify and track sequences
  u2u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready)
  );

  // Descriptor queue
  u2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // Back end: emit units
  u2u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb_utf8_to_utf16_transcoder.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder
// Self-checking bench for the UTF-8 to UTF-16 transcoder. A clocked driver
// feeds byte beats from a queue in random bursts. A clocked monitor decodes
// every accepted byte with its own model and holds the code units due. It
// then compares each accepted output beat with the oldest unit due, field by
// field. The stimulus is a directed set of sequences followed by random
// strings, mostly well formed, with broken, truncated and stray bytes mixed
// in. The receiver stalls on its own pattern and holds off once for a long
// stretch.
// ---------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder;
  import u2u_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_UNITS    = 4;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_HALF  = 200;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_mode_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  u2u_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  u2u_out_t out_data;

  // Stimulus and expectation stores
  u2u_in_t  byte_queue[$];
  u2u_out_t units_due[$];
  u2u_out_t fresh_units[$];

  // Decoder model state
  logic [2:0]  seq_len = '0;
  logic [1:0]  held    = '0;
  logic [20:0] partial = '0;

  int errors       = 0;
  int in_beats     = 0;
  int quiet_cycles = 0;

  // Driver burst control
  int burst_left = 1;
  int gap_left   = 0;

  // Receiver control
  rx_mode_t rx_mode   = RX_FREE;
  int       rx_left   = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;

  utf8_to_utf16_transcoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---- Decoder model ------------------------------------------------------

  function automatic u2u_class_t class_of(input logic [7:0] b);
    if (!b[7]) return CLS_ASCII;
    if (!b[6]) return CLS_CONT;
    if (!b[5]) return CLS_LEAD2;
    if (!b[4]) return CLS_LEAD3;
    if (!b[3]) return CLS_LEAD4;
    return CLS_INVALID;
  endfunction

  // At most four units come from one byte
  function automatic void add_unit(input logic [15:0] u);
    u2u_out_t e;
    if (fresh_units.size() < MAX_UNITS) begin
      e.code_unit = u;
      e.last_unit = 1'b0;
      fresh_units.push_back(e);
    end
  endfunction

  // One '?' per byte held, then back to no sequence
  function automatic void flush_held();
    for (int i = 0; i < int'(held); i++) add_unit(UNIT_QMARK);
    seq_len = '0;
    held    = '0;
    partial = '0;
  endfunction

  function automatic void decode_byte(input u2u_in_t beat);
    u2u_class_t  cls;
    logic        consumed;
    logic [20:0] v;
    u2u_out_t    e;
    cls      = class_of(beat.in_byte);
    consumed = 1'b0;

    // Continue or break a pending sequence
    if (seq_len != '0) begin
      if (cls == CLS_CONT) begin
        partial = {partial[14:0], beat.in_byte[5:0]};
        if (int'(held) + 1 >= int'(seq_len)) begin
          if (partial < SUPP_BASE) begin
            add_unit(partial[15:0]);
          end else begin
            v = partial - SUPP_BASE;
            add_unit(HIGH_SURR_BASE + {5'b0, v[20:10]});
            add_unit(LOW_SURR_BASE + {6'b0, v[9:0]});
          end
          seq_len = '0;
          held    = '0;
          partial = '0;
        end else begin
          held = held + 2'd1;
        end
        consumed = 1'b1;
      end else begin
        flush_held();
      end
    end

    // Byte taken on its own, or as a new lead
    if (!consumed) begin
      case (cls)
        CLS_ASCII:             add_unit({8'h00, beat.in_byte});
        CLS_CONT, CLS_INVALID: add_unit(UNIT_QMARK);
        default: begin
          seq_len = 3'(cls);
          held    = 2'd1;
          case (cls)
            CLS_LEAD2: partial = {16'b0, beat.in_byte[4:0]};
            CLS_LEAD3: partial = {17'b0, beat.in_byte[3:0]};
            default:   partial = {18'b0, beat.in_byte[2:0]};
          endcase
        end
      endcase
    end

    // End of string: flush what is left and mark the final unit
    if (beat.end_of_string) begin
      if (seq_len != '0) flush_held();
      if (fresh_units.size() > 0) begin
        e = fresh_units.pop_back();
        e.last_unit = 1'b1;
        fresh_units.push_back(e);
      end
    end

    foreach (fresh_units[i]) units_due.push_back(fresh_units[i]);
    fresh_units.delete();
  endfunction

  // ---- Stimulus helpers ---------------------------------------------------

  function automatic void push_byte(input logic [7:0] b, input logic eos);
    u2u_in_t beat;
    beat.in_byte       = b;
    beat.end_of_string = eos;
    byte_queue.push_back(beat);
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] rand_trail();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  function automatic void load_directed();
    // ASCII extremes, the zero byte among them
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    // Two- and three-byte sequences
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    // Four bytes giving a surrogate pair
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    // Highest four-byte lead, code point past the Unicode range
    push_byte(8'hF7, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    // Stray continuation and invalid lead
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    // Three held bytes broken by an invalid lead at end of string: four units
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'hF8, 1'b1);
    // Sequence broken by a new lead, which then decodes
    push_byte(8'hE2, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    // Truncated sequences at end of string
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b1);
    push_byte(8'hC3, 1'b1);
  endfunction

  // Mostly well-formed sequences; some broken, truncated or stray bytes
  function automatic void load_random(input int count);
    int   made;
    int   kind;
    int   len;
    int   cut;
    logic eos;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      eos  = ($urandom_range(0, 7) == 0);
      if (kind < 7) begin
        len = $urandom_range(1, 4);
        push_byte(lead_byte(len), (len == 1) ? eos : 1'b0);
        for (int i = 1; i < len; i++) push_byte(rand_trail(), (i == len - 1) ? eos : 1'b0);
        made += len;
      end else if (kind == 7) begin
        len = $urandom_range(2, 4);
        cut = $urandom_range(1, len - 1);
        push_byte(lead_byte(len), (cut == 1) ? eos : 1'b0);
        for (int i = 1; i < cut; i++) push_byte(rand_trail(), (i == cut - 1) ? eos : 1'b0);
        made += cut;
      end else if (kind == 8) begin
        push_byte(($urandom_range(0, 1) == 0) ? rand_trail() : 8'($urandom_range(248, 255)), eos);
        made++;
      end else begin
        push_byte(8'($urandom_range(0, 255)), eos);
        made++;
      end
    end
  endfunction

  // Sender pauses until every unit due has come out
  task automatic wait_idle();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || units_due.size() != 0) @(negedge clk);
  endtask

  // ---- Driver: bursts of beats with random gaps ---------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_data  <= byte_queue.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---- Receiver: changing stall pattern, one long hold-off ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && in_beats >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left <= 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 40);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HALF:  out_ready <= ($urandom_range(0, 1) != 0);
        default:  out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---- Monitor: predict on input beats, check output beats ----------------
  always @(posedge clk) begin
    u2u_out_t want;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        in_beats <= in_beats + 1;
      end
      if (out_valid && out_ready) begin
        if (units_due.size() == 0) begin
          $error("unexpected unit: code_unit %h last_unit %b",
                 out_data.code_unit, out_data.last_unit);
          errors++;
        end else begin
          want = units_due.pop_front();
          if (out_data.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, out_data.code_unit);
            errors++;
          end
          if (out_data.last_unit !== want.last_unit) begin
            $error("last_unit: expected %b, got %b", want.last_unit, out_data.last_unit);
            errors++;
          end
        end
      end
      quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : quiet_cycles + 1;
    end
  end

  // ---- Watchdog: too long with no beat on either side ---------------------
  initial begin
    wait (rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("utf8_to_utf16_transcoder: mismatch");
    $finish;
  end

  // ---- Sequence of the run ------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    load_directed();
    wait_idle();
    load_random(RANDOM_HALF);
    wait_idle();
    load_random(RANDOM_HALF);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && units_due.size() == 0) begin
      $display("utf8_to_utf16_transcoder: match");
    end else begin
      $display("utf8_to_utf16_transcoder: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/u2u_pkg.sv
design/u2u_front.sv
design/u2u_queue.sv
design/u2u_back.sv
design/utf8_to_utf16_transcoder.sv
tb/tb_utf8_to_utf16_transcoder.sv
